FILE: rtl/plr_pkg.sv
package plr_pkg;

    localparam int COORD_BITS = 10;
    // Error term: one sign bit plus room for one and a half major deltas
    localparam int ERR_BITS   = COORD_BITS + 2;

    localparam int S_FIELD_BITS  = 4 * COORD_BITS + 2;
    localparam int S_TDATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS  = 2 * COORD_BITS + 1;
    localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STYLE_ERASE  = 2'd0,
        STYLE_SOLID  = 2'd1,
        STYLE_DOTTED = 2'd2,
        STYLE_DASHED = 2'd3
    } style_t;

    function automatic logic style_on(input style_t style, input logic [1:0] n);
        logic on;
        case (style)
            STYLE_ERASE:  on = 1'b0;
            STYLE_SOLID:  on = 1'b1;
            STYLE_DOTTED: on = n[0];
            STYLE_DASHED: on = n[1];
            default:      on = 1'b1;
        endcase
        return on;
    endfunction

    function automatic coord_t step_coord(input coord_t c, input logic negative);
        return negative ? c - coord_t'(1) : c + coord_t'(1);
    endfunction

endpackage

FILE: rtl/patterned_line_rasterizer.sv
// Patterned line rasterizer: Bresenham line walker with a dash pattern.
//
// Input channel (s_*): tuser carries the operation. A load item latches the
// two endpoints and the line style from tdata and makes the block busy; it
// gives no result. Each tick item while busy gives one pixel on the result
// channel (m_*), then advances one Bresenham step. A tick while idle is
// consumed and gives nothing. A load while busy replaces the current line.
//
// Timing: one item per clock while s_tready is high. A tick accepted at one
// edge shows its pixel on m_* from the next cycle; the step is one add and
// compare on the error term. The output register decouples the sides: s_tready
// stays high while the result register is empty or being taken, so a stalled
// receiver holds the pending pixel and stalls the input only after that one item.
// m_tlast marks the pixel on the line's end coordinate; the block then idles.
//
// Reset (aresetn low, synchronous) clears the walker state and drops any
// pending result.
module patterned_line_rasterizer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_x, start_y, end_x, end_y, line_style, zero pad
    input  logic [plr_pkg::S_TDATA_BITS-1:0] s_tdata,
    // operation
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x, pixel_y, pixel_on, zero pad
    output logic [plr_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                             m_tlast
);
    import plr_pkg::*;

    logic   busy_reg, busy_next;
    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t major_end_reg, major_end_next;
    coord_t abs_dx_reg, abs_dx_next;
    coord_t abs_dy_reg, abs_dy_next;
    logic   step_x_neg_reg, step_x_neg_next;
    logic   step_y_neg_reg, step_y_neg_next;
    logic   x_major_reg, x_major_next;
    err_t   error_acc_reg, error_acc_next;
    logic [1:0] pattern_count_reg, pattern_count_next;
    style_t style_reg, style_next;

    logic   m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0] m_data_reg, m_data_next;
    logic   m_last_reg, m_last_next;

    logic   s_accept;
    op_t    op;
    coord_t in_sx, in_sy, in_ex, in_ey;
    style_t in_style;
    logic   ex_gt, ey_gt;
    coord_t load_dx, load_dy;

    logic [1:0] n;
    coord_t major_now, dmaj, dmin;
    logic   last;
    err_t   err_sum;
    logic signed [ERR_BITS:0] err_dbl;
    logic   minor_step;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);

    assign in_sx    = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_sy    = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_ex    = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_ey    = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_style = style_t'(s_tdata[4*COORD_BITS +: 2]);

    assign ex_gt   = in_ex > in_sx;
    assign ey_gt   = in_ey > in_sy;
    assign load_dx = ex_gt ? in_ex - in_sx : in_sx - in_ex;
    assign load_dy = ey_gt ? in_ey - in_sy : in_sy - in_ey;

    assign n          = pattern_count_reg + 2'd1;
    assign major_now  = x_major_reg ? cur_x_reg : cur_y_reg;
    assign last       = major_now == major_end_reg;
    assign dmaj       = x_major_reg ? abs_dx_reg : abs_dy_reg;
    assign dmin       = x_major_reg ? abs_dy_reg : abs_dx_reg;
    assign err_sum    = error_acc_reg + err_t'({2'b00, dmin});
    assign err_dbl    = {err_sum, 1'b0};
    assign minor_step = err_dbl >= $signed({3'b000, dmaj});

    always_comb begin
        busy_next          = busy_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        major_end_next     = major_end_reg;
        abs_dx_next        = abs_dx_reg;
        abs_dy_next        = abs_dy_reg;
        step_x_neg_next    = step_x_neg_reg;
        step_y_neg_next    = step_y_neg_reg;
        x_major_next       = x_major_reg;
        error_acc_next     = error_acc_reg;
        pattern_count_next = pattern_count_reg;
        style_next         = style_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (s_accept) begin
            if (op == OP_LOAD) begin
                step_x_neg_next    = !ex_gt;
                step_y_neg_next    = !ey_gt;
                abs_dx_next        = load_dx;
                abs_dy_next        = load_dy;
                x_major_next       = load_dx > load_dy;
                major_end_next     = (load_dx > load_dy) ? in_ex : in_ey;
                cur_x_next         = in_sx;
                cur_y_next         = in_sy;
                error_acc_next     = '0;
                pattern_count_next = 2'd0;
                style_next         = in_style;
                busy_next          = 1'b1;
            end else if (busy_reg) begin
                m_valid_next       = 1'b1;
                m_data_next        = '0;
                m_data_next[0*COORD_BITS +: COORD_BITS] = cur_x_reg;
                m_data_next[1*COORD_BITS +: COORD_BITS] = cur_y_reg;
                m_data_next[2*COORD_BITS]               = style_on(style_reg, n);
                m_last_next        = last;
                pattern_count_next = n;
                if (last) begin
                    busy_next = 1'b0;
                end else begin
                    // Major axis always advances; minor axis when 2*err reaches dmaj
                    if (x_major_reg) begin
                        cur_x_next = step_coord(cur_x_reg, step_x_neg_reg);
                        if (minor_step) begin
                            cur_y_next = step_coord(cur_y_reg, step_y_neg_reg);
                        end
                    end else begin
                        cur_y_next = step_coord(cur_y_reg, step_y_neg_reg);
                        if (minor_step) begin
                            cur_x_next = step_coord(cur_x_reg, step_x_neg_reg);
                        end
                    end
                    error_acc_next = minor_step ? err_sum - err_t'({2'b00, dmaj})
                                                : err_sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg          <= 1'b0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            major_end_reg     <= '0;
            abs_dx_reg        <= '0;
            abs_dy_reg        <= '0;
            step_x_neg_reg    <= 1'b0;
            step_y_neg_reg    <= 1'b0;
            x_major_reg       <= 1'b0;
            error_acc_reg     <= '0;
            pattern_count_reg <= 2'd0;
            style_reg         <= STYLE_ERASE;
            m_valid_reg       <= 1'b0;
        end else begin
            busy_reg          <= busy_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            major_end_reg     <= major_end_next;
            abs_dx_reg        <= abs_dx_next;
            abs_dy_reg        <= abs_dy_next;
            step_x_neg_reg    <= step_x_neg_next;
            step_y_neg_reg    <= step_y_neg_next;
            x_major_reg       <= x_major_next;
            error_acc_reg     <= error_acc_next;
            pattern_count_reg <= pattern_count_next;
            style_reg         <= style_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && op == OP_LOAD |=>
            busy_reg && error_acc_reg == '0 && pattern_count_reg == 2'd0)
        else $error("load did not restart the walker");

    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (op == OP_LOAD || !busy_reg) |=> !m_valid_reg)
        else $error("result appeared for a load or an idle tick");

    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && op == OP_TICK && busy_reg && last |=>
            !busy_reg && m_valid_reg && m_last_reg)
        else $error("last pixel did not end the line");

    a_tick_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && op == OP_TICK && busy_reg |=>
            m_valid_reg && pattern_count_reg == $past(n))
        else $error("tick while busy gave no pixel");

endmodule

FILE: sim/patterned_line_rasterizer_tb.sv
`timescale 1ns / 100ps

module patterned_line_rasterizer_tb;
    import plr_pkg::*;

    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 200;

    typedef struct packed {
        coord_t col;
        coord_t row;
        logic   on;
        logic   last;
    } pixel_t;

    // Line walker prediction and the queue of pixels still to come out
    class pixel_scoreboard;
        bit     busy;
        coord_t cur_x, cur_y, major_end, abs_dx, abs_dy;
        bit     neg_x, neg_y, x_major;
        err_t   err;
        logic [1:0] count;
        style_t style;
        pixel_t pixel_q[$];
        int     errors, lines_loaded, pixels_predicted, pixels_seen, idle_ticks;

        function void clear();
            busy = 0;
            cur_x = '0; cur_y = '0; major_end = '0; abs_dx = '0; abs_dy = '0;
            neg_x = 0; neg_y = 0; x_major = 0;
            err = '0; count = '0; style = STYLE_ERASE;
            pixel_q.delete();
            errors = 0; lines_loaded = 0; pixels_predicted = 0;
            pixels_seen = 0; idle_ticks = 0;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function int counted();
            return lines_loaded + pixels_predicted;
        endfunction

        function coord_t nudge(coord_t c, bit down);
            return down ? c - coord_t'(1) : c + coord_t'(1);
        endfunction

        function logic pattern_on(style_t s, logic [1:0] n);
            case (s)
                STYLE_ERASE:  return 1'b0;
                STYLE_DOTTED: return n[0];
                STYLE_DASHED: return n >= 2'd2;
                default:      return 1'b1;
            endcase
        endfunction

        function void note_input(op_t op, logic [S_TDATA_BITS-1:0] data);
            coord_t sx, sy, ex, ey, major_now;
            pixel_t px;
            logic [1:0] n;
            int dmaj, dmin, e;
            if (op == OP_LOAD) begin
                sx = data[0 +: COORD_BITS];
                sy = data[COORD_BITS +: COORD_BITS];
                ex = data[2*COORD_BITS +: COORD_BITS];
                ey = data[3*COORD_BITS +: COORD_BITS];
                neg_x = !(ex > sx);
                neg_y = !(ey > sy);
                abs_dx = (ex > sx) ? ex - sx : sx - ex;
                abs_dy = (ey > sy) ? ey - sy : sy - ey;
                x_major = abs_dx > abs_dy;
                major_end = x_major ? ex : ey;
                cur_x = sx;
                cur_y = sy;
                err = '0;
                count = '0;
                style = style_t'(data[4*COORD_BITS +: 2]);
                busy = 1;
                lines_loaded++;
                return;
            end
            if (!busy) begin
                idle_ticks++;
                return;
            end
            n = count + 2'd1;
            major_now = x_major ? cur_x : cur_y;
            px.col  = cur_x;
            px.row  = cur_y;
            px.on   = pattern_on(style, n);
            px.last = (major_now == major_end);
            pixel_q.push_back(px);
            pixels_predicted++;
            count = n;
            if (px.last) begin
                busy = 0;
                return;
            end
            dmaj = x_major ? int'(abs_dx) : int'(abs_dy);
            dmin = x_major ? int'(abs_dy) : int'(abs_dx);
            e = int'(err) + dmin;
            if (x_major) begin
                cur_x = nudge(cur_x, neg_x);
                if (2 * e >= dmaj) begin
                    cur_y = nudge(cur_y, neg_y);
                    e -= dmaj;
                end
            end else begin
                cur_y = nudge(cur_y, neg_y);
                if (2 * e >= dmaj) begin
                    cur_x = nudge(cur_x, neg_x);
                    e -= dmaj;
                end
            end
            err = err_t'(e);
        endfunction

        function void mismatch(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] data, logic tlast);
            pixel_t want, got;
            got.col  = data[0 +: COORD_BITS];
            got.row  = data[COORD_BITS +: COORD_BITS];
            got.on   = data[2*COORD_BITS];
            got.last = tlast;
            pixels_seen++;
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d on=%0b last=%0b",
                         $time, got.col, got.row, got.on, got.last);
                return;
            end
            want = pixel_q.pop_front();
            if (got.col !== want.col)
                mismatch("pixel_x", 16'(want.col), 16'(got.col));
            if (got.row !== want.row)
                mismatch("pixel_y", 16'(want.row), 16'(got.row));
            if (got.on !== want.on)
                mismatch("pixel_on", 16'(want.on), 16'(got.on));
            if (got.last !== want.last)
                mismatch("last_pixel", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tlast;

    pixel_scoreboard sb;
    bit sender_burst   = 0;
    bit receiver_burst = 0;
    int cycles         = 0;

    patterned_line_rasterizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycles, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [S_TDATA_BITS-1:0] pack_line(int sx, int sy, int ex, int ey,
                                                          style_t s);
        logic [S_TDATA_BITS-1:0] d;
        d = '0;
        d[0 +: COORD_BITS]            = coord_t'(sx);
        d[COORD_BITS +: COORD_BITS]   = coord_t'(sy);
        d[2*COORD_BITS +: COORD_BITS] = coord_t'(ex);
        d[3*COORD_BITS +: COORD_BITS] = coord_t'(ey);
        d[4*COORD_BITS +: 2]          = s;
        return d;
    endfunction

    function automatic logic [S_TDATA_BITS-1:0] junk_payload();
        return pack_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         style_t'($urandom_range(0, 3)));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Callers chain items within one time step; valid drops only for a gap
    task automatic send_item(input op_t op, input logic [S_TDATA_BITS-1:0] data);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, data);
    endtask

    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input style_t s, input int ticks);
        send_item(OP_LOAD, pack_line(sx, sy, ex, ey, s));
        repeat (ticks) send_item(OP_TICK, junk_payload());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_line(input int span);
        int sx, sy, ex, ey, d, pixels, ticks, kind;
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        d = $urandom_range(0, span);
        if ($urandom_range(0, 1)) d = -d;
        ex = clamp_coord(sx + d);
        d = $urandom_range(0, span);
        if ($urandom_range(0, 1)) d = -d;
        ey = clamp_coord(sy + d);
        pixels = ((ex > sx ? ex - sx : sx - ex) > (ey > sy ? ey - sy : sy - ey) ?
                  (ex > sx ? ex - sx : sx - ex) : (ey > sy ? ey - sy : sy - ey)) + 1;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            ticks = $urandom_range(0, pixels - 1);     // cut short by the next load
        else if (kind == 1)
            ticks = pixels + $urandom_range(1, 3);     // run past the end
        else
            ticks = pixels;
        send_line(sx, sy, ex, ey, style_t'($urandom_range(0, 3)), ticks);
    endtask

    // Result side: random stalls, one long hold to back up the input
    initial begin
        int gap;
        wait (aresetn == 1'b1);
        forever begin
            if (sb.pixels_seen % 40 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            gap = receiver_burst ? 0 : $urandom_range(0, 13);
            if (sb.pixels_seen == HOLD_AT)
                gap = HOLD_LEN;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata, m_tlast);
        end
    end

    initial begin
        int base, sx, sy;
        bit paused;
        sb = new;
        sb.clear();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines: extremes, every style, idle ticks, replacement
        send_item(OP_TICK, junk_payload());
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, STYLE_SOLID, 2);
        send_line(COORD_MAX - 2, 7, COORD_MAX, 7, STYLE_DOTTED, 3);
        send_line(3, 2, 3, 0, STYLE_ERASE, 3);
        send_line(0, COORD_MAX, 3, COORD_MAX - 3, STYLE_SOLID, 4);
        send_line(0, 0, COORD_MAX, 5, STYLE_SOLID, 2);
        send_line(10, 10, 12, 15, STYLE_DASHED, 7);

        // One full-span line while the receiver holds off
        sender_burst = 1;
        sx = $urandom_range(0, 1) ? COORD_MAX : 0;
        sy = $urandom_range(0, COORD_MAX);
        send_line(sx, sy, COORD_MAX - sx, $urandom_range(0, COORD_MAX),
                  style_t'($urandom_range(0, 3)), COORD_MAX + 1);

        base = sb.counted();
        paused = 0;
        while (sb.counted() - base < RAND_ITEMS) begin
            sender_burst = ($urandom_range(0, 5) == 0);
            if (!paused && sb.counted() - base > RAND_ITEMS / 2) begin
                paused = 1;
                drain();
            end
            random_line($urandom_range(0, 9) == 0 ? 64 : 12);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Walked %0d lines in all four styles, %0d pixels checked, %0d idle ticks",
                 sb.lines_loaded, sb.pixels_seen, sb.idle_ticks);
        $display("Included a full-span line, replaced lines and a long output stall");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
